// File: sv/peltier_cup_thermal_controller_top_assert.svh
// Assertion macros for the thermal controller top level.
`ifndef PELTIER_CUP_THERMAL_CONTROLLER_TOP_ASSERT_SVH
`define PELTIER_CUP_THERMAL_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication
`define PTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptc assertion failed");

// next-cycle implication
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptc assertion failed");

`endif

// File: sv/ptc_pkg.sv
`default_nettype none

package ptc_pkg;

    localparam int ADC_BITS   = 12;
    localparam int TEMP_W     = 8;
    localparam int AMB_W      = 13;
    localparam int LIMIT_W    = 8;
    localparam int CFG_IDX_W  = 1;

    // x -> 77 - 12*x/458, 12/458 as 439584 / 2^24 (exact for 12-bit x)
    localparam int CONV_OFS   = 77;
    localparam int CONV_MUL   = 439584;
    localparam int CONV_MUL_W = 19;
    localparam int CONV_SHIFT = 24;
    localparam int PROD_W     = ADC_BITS + CONV_MUL_W;

    localparam int AMB_OFS    = 915;
    localparam int AMB_OFF_W  = 4;
    localparam int OFF_IDLE   = 7;
    localparam int OFF_HEAT   = 9;
    localparam int OFF_FAN    = 3;
    localparam int HI_CAP     = 65;
    localparam int SINK_HALT  = 65;

    localparam int AMB20_W    = AMB_W + 5;
    localparam int DIVN_W     = 16;
    localparam int DIVD_W     = 8;
    localparam int DIV_CNT_W  = $clog2(DIVN_W + 1);
    localparam int QUO_W      = DIVN_W + 1;
    localparam int CMP_W      = 19;

    localparam int AVG_RESET  = 25;

    typedef enum logic [1:0] {
        DRIVE_OFF  = 2'd0,
        DRIVE_HEAT = 2'd1,
        DRIVE_COOL = 2'd2
    } t_drive;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_LIMIT = 1'b0,
        CFG_LOW_LIMIT  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        COND_NONE     = 2'd0,
        COND_DIV_BUSY = 2'd1,
        COND_OUT_FULL = 2'd2
    } t_cond;

    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] UPC_FRONT = 3'd0;
    localparam logic [PC_W-1:0] UPC_SINK  = 3'd1;
    localparam logic [PC_W-1:0] UPC_CUPT  = 3'd2;
    localparam logic [PC_W-1:0] UPC_DIV   = 3'd3;
    localparam logic [PC_W-1:0] UPC_WAIT  = 3'd4;
    localparam logic [PC_W-1:0] UPC_QUOT  = 3'd5;
    localparam logic [PC_W-1:0] UPC_DONE  = 3'd6;

    typedef struct packed {
        logic ld_prod;
        logic mul_cup;
        logic ld_front;
        logic ld_sd;
        logic ld_t;
        logic div_start;
        logic ld_q;
        logic commit;
    } t_ctl;

    typedef struct packed {
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            last;
        t_ctl            act;
    } t_uop;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } t_stat;

    // microprogram; a step whose condition holds jumps and skips its actions
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '0;
        unique case (pc)
            UPC_FRONT: begin
                u.act.ld_front = 1'b1;
                u.act.ld_prod  = 1'b1;
            end
            UPC_SINK: begin
                u.act.ld_sd    = 1'b1;
                u.act.ld_prod  = 1'b1;
                u.act.mul_cup  = 1'b1;
            end
            UPC_CUPT: begin
                u.act.ld_t     = 1'b1;
            end
            UPC_DIV: begin
                u.act.div_start = 1'b1;
            end
            UPC_WAIT: begin
                u.cond   = COND_DIV_BUSY;
                u.target = UPC_WAIT;
            end
            UPC_QUOT: begin
                u.act.ld_q = 1'b1;
            end
            UPC_DONE: begin
                u.cond       = COND_OUT_FULL;
                u.target     = UPC_DONE;
                u.act.commit = 1'b1;
                u.last       = 1'b1;
            end
            default: begin
                u.last = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// File: sv/ptc_in_if.sv
`default_nettype none

interface ptc_in_if;
    logic                           valid;
    logic                           ready;
    logic [ptc_pkg::ADC_BITS-1:0]   raw_cup;
    logic [ptc_pkg::ADC_BITS-1:0]   raw_sink;
    logic [ptc_pkg::ADC_BITS-1:0]   raw_ambient;

    modport source (output valid, output raw_cup, output raw_sink, output raw_ambient,
                    input ready);
    modport sink   (input valid, input raw_cup, input raw_sink, input raw_ambient,
                    output ready);
endinterface

`default_nettype wire

// File: sv/ptc_out_if.sv
`default_nettype none

interface ptc_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         drive;
    logic                               fan_on;
    logic                               halted;
    logic                               heat_mode;
    logic signed [ptc_pkg::TEMP_W-1:0]  cup_temp;
    logic signed [ptc_pkg::TEMP_W-1:0]  sink_temp;
    logic signed [ptc_pkg::AMB_W-1:0]   ambient_temp;

    modport source (output valid, output drive, output fan_on, output halted,
                    output heat_mode, output cup_temp, output sink_temp,
                    output ambient_temp, input ready);
    modport sink   (input valid, input drive, input fan_on, input halted,
                    input heat_mode, input cup_temp, input sink_temp,
                    input ambient_temp, output ready);
endinterface

`default_nettype wire

// File: sv/ptc_cfg_if.sv
`default_nettype none

interface ptc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ptc_pkg::CFG_IDX_W-1:0]  index;
    logic [ptc_pkg::LIMIT_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/peltier_cup_thermal_controller_top.sv
// Each item passes through a serial divider for 20*amb/t that forms one quotient bit per cycle.
// No new item is accepted until the current one has been committed.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low): averages 25, heating mode, relays off, limits 0.
`default_nettype none

`include "peltier_cup_thermal_controller_top_assert.svh"

module peltier_cup_thermal_controller_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ptc_in_if.sink      i_in,
    ptc_cfg_if.sink     i_cfg,
    ptc_out_if.source   o_out
);

    logic           busy;
    logic           start;
    ptc_pkg::t_ctl  ctl;
    ptc_pkg::t_stat stat;

    assign start       = i_in.valid && i_in.ready;
    assign i_in.ready  = !busy;
    assign i_cfg.ready = 1'b1;

    ptc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    ptc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (start),
        .i_raw_cup      (i_in.raw_cup),
        .i_raw_sink     (i_in.raw_sink),
        .i_raw_ambient  (i_in.raw_ambient),
        .i_cfg_we       (i_cfg.valid && i_cfg.ready),
        .i_cfg_idx      (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_ctl          (ctl),
        .i_out_ready    (o_out.ready),
        .o_stat         (stat),
        .o_out_valid    (o_out.valid),
        .o_drive        (o_out.drive),
        .o_fan_on       (o_out.fan_on),
        .o_halted       (o_out.halted),
        .o_heat_mode    (o_out.heat_mode),
        .o_cup_temp     (o_out.cup_temp),
        .o_sink_temp    (o_out.sink_temp),
        .o_ambient_temp (o_out.ambient_temp)
    );

    `PTC_ASSERT_NOW(a_halt_relays_off, i_clk, i_rst_n, o_out.valid && o_out.halted, o_out.drive == ptc_pkg::DRIVE_OFF && !o_out.fan_on)
    `PTC_ASSERT_NEXT(a_accept_runs, i_clk, i_rst_n, start, busy)
    `PTC_ASSERT_NOW(a_commit_div_done, i_clk, i_rst_n, ctl.commit, !stat.div_busy)
    `PTC_ASSERT_NOW(a_valid_from_commit, i_clk, i_rst_n, $rose(o_out.valid), $past(ctl.commit))

endmodule

`default_nettype wire

// File: sv/ptc_div.sv
`default_nettype none

module ptc_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [ptc_pkg::DIVN_W-1:0]     i_num,
    input  wire logic [ptc_pkg::DIVD_W-1:0]     i_den,
    output logic                                o_busy,
    output logic [ptc_pkg::DIVN_W-1:0]          o_quo
);

    logic [ptc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [ptc_pkg::DIVN_W-1:0]    r_quo;
    logic [ptc_pkg::DIVD_W-1:0]    r_rem;
    logic [ptc_pkg::DIVD_W-1:0]    r_den;
    logic [ptc_pkg::DIVD_W:0]      shifted;
    logic [ptc_pkg::DIVD_W:0]      trial;
    logic                          fits;

    // restoring, one quotient bit per cycle
    always_comb begin
        shifted = {r_rem, r_quo[ptc_pkg::DIVN_W-1]};
        trial   = shifted - {1'b0, r_den};
        fits    = (shifted >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= ptc_pkg::DIV_CNT_W'(ptc_pkg::DIVN_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[ptc_pkg::DIVN_W-2:0], fits};
            r_rem <= fits ? trial[ptc_pkg::DIVD_W-1:0] : shifted[ptc_pkg::DIVD_W-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// File: sv/ptc_seq.sv
`default_nettype none

module ptc_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire ptc_pkg::t_stat i_stat,
    output logic                o_busy,
    output ptc_pkg::t_ctl       o_ctl
);

    logic                       r_run;
    logic                       n_run;
    logic [ptc_pkg::PC_W-1:0]   r_pc;
    logic [ptc_pkg::PC_W-1:0]   n_pc;
    ptc_pkg::t_uop              word;
    logic                       hold;

    always_comb begin
        word = ptc_pkg::ucode(r_pc);
        unique case (word.cond)
            ptc_pkg::COND_NONE:     hold = 1'b0;
            ptc_pkg::COND_DIV_BUSY: hold = i_stat.div_busy;
            ptc_pkg::COND_OUT_FULL: hold = i_stat.out_full;
            default:                hold = 1'b0;
        endcase
        o_ctl = (r_run && !hold) ? word.act : '0;

        n_run = r_run;
        n_pc  = r_pc;
        if (!r_run) begin
            if (i_start) begin
                n_run = 1'b1;
                n_pc  = ptc_pkg::UPC_FRONT;
            end
        end else if (hold) begin
            n_pc = word.target;
        end else if (word.last) begin
            n_run = 1'b0;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pc  <= ptc_pkg::UPC_FRONT;
        end else begin
            r_run <= n_run;
            r_pc  <= n_pc;
        end
    end

    assign o_busy = r_run;

endmodule

`default_nettype wire

// File: sv/ptc_dp.sv
`default_nettype none

module ptc_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_load,
    input  wire logic [ptc_pkg::ADC_BITS-1:0]       i_raw_cup,
    input  wire logic [ptc_pkg::ADC_BITS-1:0]       i_raw_sink,
    input  wire logic [ptc_pkg::ADC_BITS-1:0]       i_raw_ambient,
    input  wire logic                               i_cfg_we,
    input  wire logic [ptc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [ptc_pkg::LIMIT_W-1:0]        i_cfg_data,
    input  wire ptc_pkg::t_ctl                      i_ctl,
    input  wire logic                               i_out_ready,
    output ptc_pkg::t_stat                          o_stat,
    output logic                                    o_out_valid,
    output logic [1:0]                              o_drive,
    output logic                                    o_fan_on,
    output logic                                    o_halted,
    output logic                                    o_heat_mode,
    output logic signed [ptc_pkg::TEMP_W-1:0]       o_cup_temp,
    output logic signed [ptc_pkg::TEMP_W-1:0]       o_sink_temp,
    output logic signed [ptc_pkg::AMB_W-1:0]        o_ambient_temp
);

    localparam int CW = ptc_pkg::CMP_W;
    localparam int TW = ptc_pkg::TEMP_W;
    localparam int AW = ptc_pkg::ADC_BITS;
    localparam logic signed [CW-1:0] K_ONE    = CW'(1);
    localparam logic signed [CW-1:0] K_TWO    = CW'(2);
    localparam logic signed [CW-1:0] K_FIVE   = CW'(5);
    localparam logic signed [CW-1:0] K_TWENTY = CW'(20);
    localparam logic signed [CW-1:0] K_HALT   = CW'(ptc_pkg::SINK_HALT);

    // state
    logic [AW-1:0]                  r_cup_avg;
    logic signed [TW-1:0]           r_sink_avg;
    logic                           r_heating;
    logic                           r_drive_act;
    logic                           r_fan;
    logic                           r_halt;
    logic [ptc_pkg::LIMIT_W-1:0]    r_high;
    logic [ptc_pkg::LIMIT_W-1:0]    r_low;
    logic                           r_ovalid;

    // working registers
    logic [AW-1:0]                  r_raw_cup;
    logic [AW-1:0]                  r_raw_sink;
    logic [AW-1:0]                  r_raw_amb;
    logic [ptc_pkg::PROD_W-1:0]     r_prod;
    logic signed [ptc_pkg::AMB_W-1:0] r_amb;
    logic signed [TW-1:0]           r_t;
    logic signed [ptc_pkg::QUO_W-1:0] r_q;

    logic [AW-1:0]                  mul_a;
    logic signed [TW-1:0]           conv_deg;
    logic signed [TW:0]             s_sum;
    logic signed [TW:0]             s_half;
    logic [AW:0]                    c_sum;
    logic [ptc_pkg::AMB_OFF_W-1:0]  amb_off;
    logic signed [ptc_pkg::AMB_W-1:0] n_amb;
    logic signed [ptc_pkg::AMB20_W-1:0] amb_x;
    logic signed [ptc_pkg::AMB20_W-1:0] amb20;
    logic [ptc_pkg::AMB20_W-1:0]    amb20_mag;
    logic [TW-1:0]                  t_mag;
    logic [ptc_pkg::DIVN_W-1:0]     quo;
    logic                           div_busy;
    logic [ptc_pkg::QUO_W-1:0]      q_mag;
    logic signed [ptc_pkg::QUO_W-1:0] n_q;

    logic signed [CW-1:0]           sd_c;
    logic signed [CW-1:0]           t_c;
    logic signed [CW-1:0]           amb_c;
    logic signed [CW-1:0]           q_c;
    logic signed [CW-1:0]           lo_c;
    logic signed [CW-1:0]           hi_c;
    logic [ptc_pkg::LIMIT_W-1:0]    hi_cap;
    logic                           n_fan;
    logic                           n_halt;
    logic                           n_drive_act;
    logic                           n_heating;
    logic [1:0]                     n_drive;

    // conversion and averaging
    always_comb begin
        mul_a    = i_ctl.mul_cup ? r_cup_avg : r_raw_sink;
        conv_deg = TW'(ptc_pkg::CONV_OFS)
                   - TW'(r_prod[ptc_pkg::PROD_W-1:ptc_pkg::CONV_SHIFT]);
        s_sum    = {r_sink_avg[TW-1], r_sink_avg} + {conv_deg[TW-1], conv_deg};
        s_half   = s_sum[TW] ? ((s_sum + (TW+1)'(1)) >>> 1) : (s_sum >>> 1);
        c_sum    = {1'b0, r_cup_avg} + {1'b0, r_raw_cup};
    end

    // ambient correction, from the relay state before the item
    always_comb begin
        if (!r_drive_act) begin
            amb_off = ptc_pkg::AMB_OFF_W'(ptc_pkg::OFF_IDLE);
        end else if (r_heating) begin
            amb_off = ptc_pkg::AMB_OFF_W'(ptc_pkg::OFF_HEAT);
        end else if (r_fan) begin
            amb_off = ptc_pkg::AMB_OFF_W'(ptc_pkg::OFF_FAN);
        end else begin
            amb_off = '0;
        end
        n_amb = {1'b0, r_raw_amb} - ptc_pkg::AMB_W'(ptc_pkg::AMB_OFS)
                - ptc_pkg::AMB_W'(amb_off);
    end

    // 20*amb/t operands and signed quotient
    always_comb begin
        amb_x     = ptc_pkg::AMB20_W'(r_amb);
        amb20     = (amb_x <<< 4) + (amb_x <<< 2);
        amb20_mag = amb20[ptc_pkg::AMB20_W-1] ? -amb20 : amb20;
        t_mag     = r_t[TW-1] ? -r_t : r_t;
        q_mag     = {1'b0, quo};
        if (r_t == '0) begin
            n_q = '0;
        end else if (r_amb[ptc_pkg::AMB_W-1] ^ r_t[TW-1]) begin
            n_q = -q_mag;
        end else begin
            n_q = q_mag;
        end
    end

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (amb20_mag[ptc_pkg::DIVN_W-1:0]),
        .i_den   (t_mag),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    // relay decision
    always_comb begin
        sd_c   = CW'(r_sink_avg);
        t_c    = CW'(r_t);
        amb_c  = CW'(r_amb);
        q_c    = CW'(r_q);
        lo_c   = $signed(CW'(r_low));
        hi_cap = (r_high > ptc_pkg::LIMIT_W'(ptc_pkg::HI_CAP))
                 ? ptc_pkg::LIMIT_W'(ptc_pkg::HI_CAP) : r_high;
        hi_c   = $signed(CW'(hi_cap));

        n_fan       = r_fan;
        n_drive_act = r_drive_act;
        n_heating   = r_heating;
        if (sd_c >= K_HALT) begin
            n_drive_act = 1'b0;
            n_halt      = 1'b1;
            n_fan       = 1'b0;
        end else begin
            if (n_heating) begin
                if (sd_c > amb_c + K_TWO) begin
                    n_fan = 1'b1;
                end else if (sd_c < amb_c) begin
                    n_fan = 1'b0;
                end
            end else begin
                if (!n_fan && sd_c <= amb_c + K_ONE) begin
                    n_fan = 1'b1;
                end else if (n_fan && sd_c > amb_c + K_FIVE) begin
                    n_fan = 1'b0;
                end
            end
            n_halt = 1'b0;
        end

        if (!n_halt && t_c <= lo_c - K_TWO && !n_heating) begin
            n_heating   = 1'b1;
            n_drive_act = 1'b1;
        end
        if (!n_halt && t_c >= hi_c + K_TWO && n_heating) begin
            n_heating   = 1'b0;
            n_drive_act = 1'b1;
        end

        if (!n_heating) begin
            if (n_drive_act && (t_c <= lo_c || (t_c <= amb_c && sd_c >= amb_c + q_c)
                                || sd_c >= t_c + K_TWENTY)) begin
                n_drive_act = 1'b0;
            end
            if (!n_halt && !n_drive_act && t_c >= hi_c &&
                ((sd_c <= t_c + K_TWO && t_c > amb_c) ||
                 (sd_c <= amb_c + K_TWO && t_c <= amb_c))) begin
                n_drive_act = 1'b1;
            end
        end else begin
            if (!n_halt && !n_drive_act && t_c <= lo_c) begin
                n_drive_act = 1'b1;
            end
            if (n_drive_act && t_c >= hi_c) begin
                n_drive_act = 1'b0;
            end
        end

        if (!n_drive_act) begin
            n_drive = ptc_pkg::DRIVE_OFF;
        end else if (n_heating) begin
            n_drive = ptc_pkg::DRIVE_HEAT;
        end else begin
            n_drive = ptc_pkg::DRIVE_COOL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cup_avg   <= AW'(ptc_pkg::AVG_RESET);
            r_sink_avg  <= TW'(ptc_pkg::AVG_RESET);
            r_heating   <= 1'b1;
            r_drive_act <= 1'b0;
            r_fan       <= 1'b0;
            r_halt      <= 1'b0;
            r_high      <= '0;
            r_low       <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ptc_pkg::CFG_HIGH_LIMIT: r_high <= i_cfg_data;
                    ptc_pkg::CFG_LOW_LIMIT:  r_low  <= i_cfg_data;
                endcase
            end
            if (i_ctl.ld_front) begin
                r_cup_avg <= c_sum[AW:1];
            end
            if (i_ctl.ld_sd) begin
                r_sink_avg <= s_half[TW-1:0];
            end
            if (i_ctl.commit) begin
                r_heating   <= n_heating;
                r_drive_act <= n_drive_act;
                r_fan       <= n_fan;
                r_halt      <= n_halt;
                r_ovalid    <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_raw_cup  <= i_raw_cup;
            r_raw_sink <= i_raw_sink;
            r_raw_amb  <= i_raw_ambient;
        end
        if (i_ctl.ld_prod) begin
            r_prod <= ptc_pkg::PROD_W'(mul_a) * ptc_pkg::PROD_W'(ptc_pkg::CONV_MUL);
        end
        if (i_ctl.ld_front) begin
            r_amb <= n_amb;
        end
        if (i_ctl.ld_t) begin
            r_t <= conv_deg;
        end
        if (i_ctl.ld_q) begin
            r_q <= n_q;
        end
        if (i_ctl.commit) begin
            o_drive        <= n_drive;
            o_fan_on       <= n_fan;
            o_halted       <= n_halt;
            o_heat_mode    <= n_heating;
            o_cup_temp     <= r_t;
            o_sink_temp    <= r_sink_avg;
            o_ambient_temp <= r_amb;
        end
    end

    assign o_stat.div_busy = div_busy;
    assign o_stat.out_full = r_ovalid && !i_out_ready;
    assign o_out_valid     = r_ovalid;

endmodule

`default_nettype wire
